// ===== rtl/core/slsi_pkg.sv =====
// Shared constants, types and codes for the sorted line-start index.
// Used by the top level and its port checker; no dependencies.
package slsi_pkg;

  localparam int MAX_LINES = 1024;
  localparam int POS_BITS  = 32;
  localparam int IDX_W     = $clog2(MAX_LINES);
  localparam int CNT_W     = $clog2(MAX_LINES + 1);

  // Stream field widths
  localparam int FUNC_W     = 3;
  localparam int FIELD_W    = 32;
  localparam int CHAR_W     = 16;
  localparam int LINE_W     = 10;
  localparam int OUT_CNT_W  = 11;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 88;

  // Bit positions in in_tdata
  localparam int IN_POS_LO  = 0;
  localparam int IN_REND_LO = IN_POS_LO + FIELD_W;
  localparam int IN_CHAR_LO = IN_REND_LO + FIELD_W;
  localparam int IN_LINE_LO = IN_CHAR_LO + CHAR_W;

  // Bit positions in out_tdata
  localparam int OUT_LINE_LO = 0;
  localparam int OUT_OFF_LO  = OUT_LINE_LO + LINE_W;
  localparam int OUT_CNT_LO  = OUT_OFF_LO + FIELD_W;
  localparam int OUT_LEN_LO  = OUT_CNT_LO + OUT_CNT_W;
  localparam int OUT_PAD_W   = OUT_DATA_W - (OUT_LEN_LO + FIELD_W);

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 16'd10;

  localparam logic [FUNC_W-1:0] FN_CLEAR    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INSERT   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_ERASE    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_OFF2LINE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_LINE2OFF = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_REVERSED = 2'd2
  } status_t;

  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [IDX_W-1:0]    idx_t;

endpackage

// ===== rtl/core/slsi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module slsi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sorted_line_start_index_unit.sv =====
// Top level of the sorted line-start index: sequencer, scan datapath and result register.
// Depends on slsi_pkg and slsi_ram.
//
// Holds a table of line-start offsets (line 0 always starts at 0) and the document length,
// and answers one result word per input word. The table sits in a single-port-read RAM and
// every pass over it walks the entries one per cycle through the same comparators
// and adders. Clear and unknown codes do not touch the table, line-to-offset reads one entry,
// insert and offset-to-line make one pass over the stored entries, and erase makes a search
// pass for both range ends, then a compaction pass over the later entries. The first entry
// is implied rather than stored, so no clearing pass is needed after reset. in_tready is high
// only between operations; a finished result waits in the output register while the next
// word is taken in.
module sorted_line_start_index_unit import slsi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // position, range_end, char_code, asked_line
  input  logic [FUNC_W-1:0]     in_tuser,   // func
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // line_number, offset, line_count, doc_length
  output logic [STATUS_W-1:0]   out_tuser   // status
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_MOVE, S_FETCH, S_READ, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  pos_t    pos_r, pos_nxt, rend_r, rend_nxt, dlen_r, dlen_nxt;
  pos_t    carry_r, carry_nxt, doclen_r, doclen_nxt, res_off_r, res_off_nxt;
  logic    grow_r, grow_nxt;
  status_t status_r, status_nxt;
  cnt_t    count_r, count_nxt, rd_idx_r, rd_idx_nxt;
  cnt_t    b_r, b_nxt, e_r, e_nxt, shift_r, shift_nxt;
  logic    pend_r, pend_nxt, found_b_r, found_b_nxt, found_e_r, found_e_nxt;
  idx_t    pend_idx_r, pend_idx_nxt;
  logic [LINE_W-1:0] res_line_r, res_line_nxt, out_line_r, out_line_nxt;
  logic    out_valid_r, out_valid_nxt;
  pos_t    out_off_r, out_off_nxt, out_len_r, out_len_nxt;
  cnt_t    out_cnt_r, out_cnt_nxt;
  status_t out_status_r, out_status_nxt;

  pos_t              in_pos, in_rend;
  logic [CHAR_W-1:0] in_char;
  logic [LINE_W-1:0] in_line;

  logic ram_we;
  idx_t ram_waddr, ram_raddr;
  pos_t ram_wdata, ram_rdata;
  logic issue, hit_b, hit_e;
  pos_t add_one, sub_len;
  cnt_t e_fix;

  assign in_pos  = POS_BITS'(in_tdata[IN_POS_LO +: FIELD_W]);
  assign in_rend = POS_BITS'(in_tdata[IN_REND_LO +: FIELD_W]);
  assign in_char = in_tdata[IN_CHAR_LO +: CHAR_W];
  assign in_line = in_tdata[IN_LINE_LO +: LINE_W];

  slsi_ram #(
    .WIDTH (POS_BITS),
    .DEPTH (MAX_LINES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign issue   = (rd_idx_r < count_r);
  assign hit_b   = (ram_rdata > pos_r);
  assign hit_e   = (ram_rdata > rend_r);
  assign add_one = ram_rdata + POS_BITS'(1);
  assign sub_len = ram_rdata - dlen_r;
  assign e_fix   = (e_r < b_r) ? b_r : e_r;
  assign ram_raddr = rd_idx_r[IDX_W-1:0];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, FIELD_W'(out_len_r), OUT_CNT_W'(out_cnt_r),
                       FIELD_W'(out_off_r), out_line_r};

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    pos_nxt        = pos_r;
    rend_nxt       = rend_r;
    dlen_nxt       = dlen_r;
    carry_nxt      = carry_r;
    doclen_nxt     = doclen_r;
    res_off_nxt    = res_off_r;
    grow_nxt       = grow_r;
    status_nxt     = status_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    b_nxt          = b_r;
    e_nxt          = e_r;
    shift_nxt      = shift_r;
    pend_nxt       = pend_r;
    found_b_nxt    = found_b_r;
    found_e_nxt    = found_e_r;
    pend_idx_nxt   = pend_idx_r;
    res_line_nxt   = res_line_r;
    out_line_nxt   = out_line_r;
    out_off_nxt    = out_off_r;
    out_len_nxt    = out_len_r;
    out_cnt_nxt    = out_cnt_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          func_nxt     = in_tuser;
          pos_nxt      = in_pos;
          rend_nxt     = in_rend;
          carry_nxt    = in_pos + POS_BITS'(1);
          status_nxt   = ST_OK;
          res_line_nxt = '0;
          res_off_nxt  = '0;
          rd_idx_nxt   = CNT_W'(1);
          pend_nxt     = 1'b0;
          found_b_nxt  = 1'b0;
          found_e_nxt  = 1'b0;
          b_nxt        = count_r;
          e_nxt        = count_r;
          grow_nxt     = 1'b0;
          case (in_tuser)
            FN_CLEAR: begin
              count_nxt  = CNT_W'(1);
              doclen_nxt = '0;
              state_nxt  = S_DONE;
            end
            FN_INSERT: begin
              grow_nxt = (in_char == NEWLINE_CODE) && (count_r < CNT_W'(MAX_LINES));
              if ((in_char == NEWLINE_CODE) && (count_r >= CNT_W'(MAX_LINES))) begin
                status_nxt = ST_FULL;
              end
              state_nxt = S_SCAN;
            end
            FN_ERASE: begin
              if (in_rend < in_pos) begin
                status_nxt = ST_REVERSED;
                state_nxt  = S_DONE;
              end else begin
                dlen_nxt  = in_rend - in_pos;
                state_nxt = S_SCAN;
              end
            end
            FN_OFF2LINE: begin
              state_nxt = S_SCAN;
            end
            FN_LINE2OFF: begin
              // past the end answers the last line
              rd_idx_nxt = (32'(in_line) >= 32'(count_r)) ? count_r - CNT_W'(1)
                                                          : CNT_W'(in_line);
              state_nxt  = S_FETCH;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        pend_nxt = issue;
        if (issue) begin
          rd_idx_nxt   = rd_idx_r + CNT_W'(1);
          pend_idx_nxt = rd_idx_r[IDX_W-1:0];
        end
        if (pend_r) begin
          if (!found_b_r && hit_b) begin
            found_b_nxt = 1'b1;
            b_nxt       = CNT_W'(pend_idx_r);
          end
          if (!found_e_r && hit_e) begin
            found_e_nxt = 1'b1;
            e_nxt       = CNT_W'(pend_idx_r);
          end
          // insert past the split: growing takes the one below plus one, else adds one
          if ((func_r == FN_INSERT) && (found_b_r || hit_b)) begin
            ram_we    = 1'b1;
            ram_waddr = pend_idx_r;
            ram_wdata = grow_r ? carry_r : add_one;
            carry_nxt = add_one;
          end
        end
        if (!issue && !pend_r) begin
          case (func_r)
            FN_INSERT: begin
              if (grow_r) begin
                ram_we    = 1'b1;
                ram_waddr = count_r[IDX_W-1:0];
                ram_wdata = carry_r;
                count_nxt = count_r + CNT_W'(1);
              end
              doclen_nxt = doclen_r + POS_BITS'(1);
              state_nxt  = S_DONE;
            end
            FN_ERASE: begin
              shift_nxt  = e_fix - b_r;
              rd_idx_nxt = e_fix;
              state_nxt  = S_MOVE;
            end
            FN_OFF2LINE: begin
              res_line_nxt = LINE_W'(b_r - CNT_W'(1));
              state_nxt    = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_MOVE: begin
        pend_nxt = issue;
        if (issue) begin
          rd_idx_nxt   = rd_idx_r + CNT_W'(1);
          pend_idx_nxt = rd_idx_r[IDX_W-1:0];
        end
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = pend_idx_r - IDX_W'(shift_r);
          ram_wdata = sub_len;
        end
        if (!issue && !pend_r) begin
          count_nxt  = count_r - shift_r;
          doclen_nxt = doclen_r - dlen_r;
          state_nxt  = S_DONE;
        end
      end

      S_FETCH: begin
        state_nxt = S_READ;
      end

      S_READ: begin
        // line 0 is not stored
        res_off_nxt = (rd_idx_r == '0) ? '0 : ram_rdata;
        state_nxt   = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_line_nxt   = res_line_r;
          out_off_nxt    = res_off_r;
          out_cnt_nxt    = count_r;
          out_len_nxt    = doclen_r;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CNT_W'(1);
      doclen_r    <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      doclen_r    <= doclen_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
    func_r       <= func_nxt;
    pos_r        <= pos_nxt;
    rend_r       <= rend_nxt;
    dlen_r       <= dlen_nxt;
    carry_r      <= carry_nxt;
    res_off_r    <= res_off_nxt;
    grow_r       <= grow_nxt;
    status_r     <= status_nxt;
    rd_idx_r     <= rd_idx_nxt;
    b_r          <= b_nxt;
    e_r          <= e_nxt;
    shift_r      <= shift_nxt;
    found_b_r    <= found_b_nxt;
    found_e_r    <= found_e_nxt;
    pend_idx_r   <= pend_idx_nxt;
    res_line_r   <= res_line_nxt;
    out_line_r   <= out_line_nxt;
    out_off_r    <= out_off_nxt;
    out_len_r    <= out_len_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

// ===== rtl/core/slsi_checker.sv =====
// Port-level checks for the sorted line-start index, bound to the top level.
// Depends on slsi_pkg and sorted_line_start_index_unit.
module slsi_checker import slsi_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,   // position, range_end, char_code, asked_line
  input logic [FUNC_W-1:0]     in_tuser,   // func
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,  // line_number, offset, line_count, doc_length
  input logic [STATUS_W-1:0]   out_tuser   // status
);

  logic [OUT_CNT_W-1:0] cnt_field;
  assign cnt_field = out_tdata[OUT_CNT_LO +: OUT_CNT_W];

  // one word in flight: busy straight after a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while previous word still in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result word changed");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (cnt_field != '0) && (32'(cnt_field) <= MAX_LINES))
    else $error("line count out of range");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL) |-> (32'(cnt_field) == MAX_LINES))
    else $error("table-full status with room left");

endmodule

bind sorted_line_start_index_unit slsi_checker u_slsi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
